/* hw/rtl/salc_pkg.sv */
// Shared constants and types for the set-associative LRU tag store.
package salc_pkg;
  localparam int unsigned LINES_LOG2 = 9;
  localparam int unsigned OFFSET_BITS = 5;
  localparam int unsigned TAG_BITS = 32 - OFFSET_BITS;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned LINES = 1 << LINES_LOG2;
  localparam logic [3:0] WAYS_LOG2_RESET = 4'd1;

  typedef logic [LINES_LOG2-1:0] line_idx_t;

  typedef struct packed {
    logic valid;
    logic [TAG_BITS-1:0] tag;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;
endpackage

/* hw/rtl/salc_tag_ram.sv */
// Tag and timestamp memory, one write and one registered read port.
module salc_tag_ram
  import salc_pkg::*;
(
  input  logic      clk,
  input  logic      we,
  input  line_idx_t waddr,
  input  entry_t    wdata,
  input  line_idx_t raddr,
  output entry_t    rdata
);
  entry_t mem [LINES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/set_assoc_lru_cache_hit_model.sv */
// Set-associative true-LRU cache tag store: one hit flag and hit count per address.
// After reset the block clears the valid bits of every line of the memory and stalls its
// input meanwhile. With w = min(ways_log2, 9), a new address is accepted only once the
// previous one has written its way back: one shared compare unit walks the 2^w ways of the
// set one per cycle, reading valid, tag and stamp from a registered-read memory, then the
// chosen way is written back. The result sits in an output register, so the next address
// can be accepted while it waits; its write-back waits until that result is taken.
module set_assoc_lru_cache_hit_model
  import salc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] hit_count
);
  typedef enum logic [1:0] {CLEAR, IDLE, SCAN, WRITE} state_t;

  state_t state;
  logic [3:0] ways_log2;
  logic [3:0] wl;
  logic [LINES_LOG2:0] ways;
  logic [LINES_LOG2:0] rd_cnt;
  line_idx_t base;
  line_idx_t clr_addr;
  logic [TAG_BITS-1:0] tag;
  logic [STAMP_BITS-1:0] access_index;
  logic [31:0] hits_so_far;
  logic ev_v;
  line_idx_t ev_w;
  logic hit_found, inv_found;
  line_idx_t hit_way, inv_way, min_way;
  logic [STAMP_BITS-1:0] min_stamp;
  entry_t rdata;
  entry_t wdata;
  line_idx_t raddr, waddr, sel_way;
  logic issue, we;
  logic [LINES_LOG2-1:0] set_mask;
  logic [31:0] tag_shifted;

  assign wl = (ways_log2 > 4'(LINES_LOG2)) ? 4'(LINES_LOG2) : ways_log2;
  assign set_mask = {LINES_LOG2{1'b1}} >> wl;
  assign tag_shifted = address >> (OFFSET_BITS + LINES_LOG2 - 32'(wl));
  assign issue = (state == SCAN) && (rd_cnt != ways);
  assign raddr = base | rd_cnt[LINES_LOG2-1:0];
  assign sel_way = hit_found ? hit_way : (inv_found ? inv_way : min_way);
  assign waddr = (state == CLEAR) ? clr_addr : (base | sel_way);
  assign wdata = (state == CLEAR) ? entry_t'('0) : entry_t'({1'b1, tag, access_index});
  assign we = (state == CLEAR) || ((state == WRITE) && (!out_valid || !out_stall));
  assign in_stall = (state != IDLE);

  salc_tag_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      clr_addr <= '0;
      ways_log2 <= WAYS_LOG2_RESET;
      access_index <= '0;
      hits_so_far <= '0;
      out_valid <= 1'b0;
      ev_v <= 1'b0;
      rd_cnt <= '0;
    end else begin
      if (cfg_we) begin
        ways_log2 <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == line_idx_t'(LINES - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            state <= SCAN;
            ways <= (LINES_LOG2+1)'(1) << wl;
            base <= (address[OFFSET_BITS +: LINES_LOG2] & set_mask) << wl;
            tag <= tag_shifted[TAG_BITS-1:0];
            rd_cnt <= '0;
            ev_v <= 1'b0;
            hit_found <= 1'b0;
            inv_found <= 1'b0;
            min_way <= '0;
          end
        end
        SCAN: begin
          ev_v <= issue;
          ev_w <= rd_cnt[LINES_LOG2-1:0];
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (ev_v) begin
            if (rdata.valid) begin
              if (!hit_found && rdata.tag == tag) begin
                hit_found <= 1'b1;
                hit_way <= ev_w;
              end
              if (ev_w == '0 || rdata.stamp < min_stamp) begin
                min_stamp <= rdata.stamp;
                min_way <= ev_w;
              end
            end else if (!inv_found) begin
              inv_found <= 1'b1;
              inv_way <= ev_w;
            end
          end
          if (!issue && !ev_v) begin
            state <= WRITE;
          end
        end
        WRITE: begin
          if (we) begin
            state <= IDLE;
            if (access_index != '1) begin
              access_index <= access_index + 1'b1;
            end
            if (hit_found && hits_so_far != '1) begin
              hits_so_far <= hits_so_far + 1'b1;
              hit_count <= hits_so_far + 1'b1;
            end else begin
              hit_count <= hits_so_far;
            end
            hit <= hit_found;
            out_valid <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == SCAN))
    else $error("accepted transaction did not start a scan");
  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hits_so_far >= $past(hits_so_far)))
    else $error("hit counter decreased");
  a_eval_in_scan: assert property (@(posedge clk) disable iff (rst)
    ev_v |-> (state == SCAN))
    else $error("way evaluation outside scan");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit_count)))
    else $error("stalled result changed");
endmodule

/* dv/tb_set_assoc_lru_cache_hit_model.sv */
// Testbench for the set-associative LRU tag store: directed and random address streams.
module tb_set_assoc_lru_cache_hit_model;
  import salc_pkg::*;

  localparam int unsigned MAX_CYCLES = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] address;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic [31:0] hit_count;

  set_assoc_lru_cache_hit_model u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .address(address),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .hit_count(hit_count)
  );

  typedef struct {
    logic        hit;
    logic [31:0] hit_count;
  } lookup_t;

  // shadow tag store
  logic [3:0]          shadow_ways_log2;
  logic                shadow_valid [LINES];
  logic [TAG_BITS-1:0] shadow_tag [LINES];
  logic [31:0]         shadow_stamp [LINES];
  logic [31:0]         shadow_now;
  logic [31:0]         shadow_hits;

  lookup_t     lookup_q[$];
  int unsigned errors;
  int unsigned cycle;
  bit          hold_off;
  logic [31:0] recent_addr[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic lookup_t predict_lookup(logic [31:0] a);
    lookup_t r;
    int unsigned wl, sl, ways, set_no, base, victim;
    logic [31:0] tg;
    bit found, filled;
    wl = (shadow_ways_log2 > LINES_LOG2) ? LINES_LOG2 : shadow_ways_log2;
    sl = LINES_LOG2 - wl;
    ways = 1 << wl;
    set_no = (a >> OFFSET_BITS) & ((1 << sl) - 1);
    tg = a >> (sl + OFFSET_BITS);
    base = set_no << wl;
    found = 0;
    for (int w = 0; w < ways; w++) begin
      if (!found && shadow_valid[base+w] && shadow_tag[base+w] == tg[TAG_BITS-1:0]) begin
        found = 1;
        shadow_stamp[base+w] = shadow_now;
      end
    end
    if (!found) begin
      filled = 0;
      for (int w = 0; w < ways; w++) begin
        if (!filled && !shadow_valid[base+w]) begin
          filled = 1;
          shadow_valid[base+w] = 1;
          shadow_tag[base+w] = tg[TAG_BITS-1:0];
          shadow_stamp[base+w] = shadow_now;
        end
      end
      if (!filled) begin
        victim = base;
        for (int w = 1; w < ways; w++)
          if (shadow_stamp[base+w] < shadow_stamp[victim]) victim = base + w;
        shadow_tag[victim] = tg[TAG_BITS-1:0];
        shadow_stamp[victim] = shadow_now;
      end
    end else if (shadow_hits != 32'hFFFF_FFFF) begin
      shadow_hits = shadow_hits + 1;
    end
    if (shadow_now != 32'hFFFF_FFFF) shadow_now = shadow_now + 1;
    r.hit = found;
    r.hit_count = shadow_hits;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && out_valid && !out_stall) begin
      if (lookup_q.size() == 0) begin
        report_mismatch("unexpected transaction", {31'd0, hit}, 0);
      end else begin
        e = lookup_q.pop_front();
        if (hit !== e.hit) report_mismatch("hit", {31'd0, hit}, {31'd0, e.hit});
        if (hit_count !== e.hit_count) report_mismatch("hit_count", hit_count, e.hit_count);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int unsigned mode;
    mode = (cycle / 2000) % 3;
    if (rst) out_stall <= 0;
    else if (hold_off) out_stall <= 1;
    else if (mode == 0) out_stall <= 0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  task automatic send_address(logic [31:0] a);
    in_valid <= 1;
    address <= a;
    do @(posedge clk); while (in_stall);
    lookup_q.push_back(predict_lookup(a));
    recent_addr.push_back(a);
    if (recent_addr.size() > 64) void'(recent_addr.pop_front());
  endtask

  task automatic idle_cycles(int unsigned n);
    in_valid <= 0;
    address <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (LINES + 8) @(posedge clk);
  endtask

  task automatic write_ways_log2(logic [3:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    shadow_ways_log2 = v;
  endtask

  task automatic test_directed();
    send_address(32'h0000_0000);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFE0);
    send_address(32'h0000_001F);
    // same set, conflicting tags: eviction under 2 ways
    send_address(32'h0000_2000);
    send_address(32'h0000_4000);
    send_address(32'h0000_0000);
    send_address(32'h0000_2000);
    send_address(32'hAAAA_AAAA);
    send_address(32'h5555_5555);
    write_ways_log2(4'd0);
    send_address(32'h0000_0000);
    send_address(32'h0000_4000);
    send_address(32'h0000_0000);
    write_ways_log2(4'd15);   // above max, saturates to fully associative
    send_address(32'h0000_0000);
    send_address(32'h1234_5678);
    send_address(32'h1234_5678);
    write_ways_log2(4'd9);
    send_address(32'h8000_0000);
    send_address(32'h8000_0000);
    write_ways_log2(4'd10);
    send_address(32'h7FFF_FFFF);
    drain();
  endtask

  function automatic logic [31:0] random_address(int unsigned footprint);
    if (recent_addr.size() != 0 && $urandom_range(0, 2) != 0)
      return recent_addr[$urandom_range(0, recent_addr.size() - 1)] ^ $urandom_range(0, 31);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return ($urandom_range(0, footprint) << OFFSET_BITS) | $urandom_range(0, 31)
           | ($urandom_range(0, 1) ? 32'hF000_0000 : 32'h0);
  endfunction

  task automatic test_random(logic [3:0] wl, int unsigned n);
    int unsigned burst;
    write_ways_log2(wl);
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_address(random_address(1023));
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_ways_log2(4'd2);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 30; i++) send_address(random_address(255));
    join
    in_valid <= 0;
    while (lookup_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 10; i++) send_address(random_address(255));
    drain();
  endtask

  initial begin
    errors = 0;
    cycle = 0;
    hold_off = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    address = 0;
    shadow_ways_log2 = WAYS_LOG2_RESET;
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 0;
      shadow_tag[i] = 0;
      shadow_stamp[i] = 0;
    end
    shadow_now = 0;
    shadow_hits = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(4'd0, 300);
    test_random(4'd1, 250);
    test_random(4'd3, 250);
    test_random(4'd6, 150);
    test_random(4'd9, 60);
    test_random(4'd12, 40);
    test_random(4'd2, 60);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/salc_pkg.sv
hw/rtl/salc_tag_ram.sv
hw/rtl/set_assoc_lru_cache_hit_model.sv
dv/tb_set_assoc_lru_cache_hit_model.sv
